FILE: hdl/etrm_pkg.sv
// ----------------------------------------------------------------------------
// Euler to rotation matrix package
// Shared types, fixed-point constants and the quarter-wave kernel coefficients.
// ----------------------------------------------------------------------------
package etrm_pkg;

  // Q2.30 signed value, Q30 product and wide sum
  localparam int SUM_W = 34;

  typedef logic signed [31:0]      q30_t;
  typedef logic signed [63:0]      prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [15:0]      elem_t;

  typedef struct packed {
    elem_t fwd_x;
    elem_t fwd_y;
    elem_t fwd_z;
    elem_t left_x;
    elem_t left_y;
    elem_t left_z;
    elem_t up_x;
    elem_t up_y;
    elem_t up_z;
  } basis_t;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam prod_t       Q30_HALF    = prod_t'(64'h2000_0000);

  // horner chain of the sine kernel, divisors and their reciprocals
  localparam int HORNER_STEPS = 5;
  localparam logic [6:0] HORNER_K [HORNER_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam int HORNER_S [HORNER_STEPS] = '{38, 38, 37, 36, 34};
  localparam logic [31:0] HORNER_M [HORNER_STEPS] = '{
    32'((64'd1 << 38) / 64'd110),
    32'((64'd1 << 38) / 64'd72),
    32'((64'd1 << 37) / 64'd42),
    32'((64'd1 << 36) / 64'd20),
    32'((64'd1 << 34) / 64'd6)
  };

  // kernel pipeline stages: scale, square, three per horner step, final product
  localparam int QS_LAT = 2 + 3 * HORNER_STEPS + 1;

  // round a Q60 product half away from zero back to Q30
  function automatic q30_t round_q30(input prod_t p);
    prod_t s;
    s = p[63] ? p + (Q30_HALF - prod_t'(1)) : p + Q30_HALF;
    return q30_t'(s >>> 30);
  endfunction

endpackage

FILE: hdl/etrm_qsine.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine kernel
// Pipelined polynomial sine over a quarter turn, Q30 in and out.
// ----------------------------------------------------------------------------
module etrm_qsine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [30:0] f_i,
  output logic        valid_o,
  output logic [30:0] sine_o
);
  import etrm_pkg::*;

  logic [61:0] xprod;
  logic [61:0] sqprod;
  logic [61:0] yprod;
  logic [30:0] x1_q;
  logic [30:0] xk1_q;
  logic [31:0] x2_q;
  logic [30:0] sine_q;
  logic        vld0_q;
  logic        vld1_q;
  logic        vldf_q;

  logic [30:0] p_c   [HORNER_STEPS+1];
  logic [30:0] x_c   [HORNER_STEPS+1];
  logic [31:0] x2_c  [HORNER_STEPS+1];
  logic        vld_c [HORNER_STEPS+1];

  // scale to radians, then square
  assign xprod  = 62'(f_i) * 62'(HALF_PI_Q30);
  assign sqprod = 62'(x1_q) * 62'(x1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= xprod[60:30];
      x2_q  <= sqprod[61:30];
      xk1_q <= x1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
      vld1_q <= vld0_q;
    end
  end

  assign p_c[0]   = Q30_ONE;
  assign x_c[0]   = xk1_q;
  assign x2_c[0]  = x2_q;
  assign vld_c[0] = vld1_q;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
    logic [62:0] vprod;
    logic [63:0] mprod;
    logic [31:0] qk;
    logic [31:0] rem;
    logic        corr;
    logic [31:0] v_q;
    logic [31:0] vb_q;
    logic [31:0] q0_q;
    logic [30:0] xa_q;
    logic [30:0] xb_q;
    logic [30:0] xc_q;
    logic [31:0] x2a_q;
    logic [31:0] x2b_q;
    logic [31:0] x2c_q;
    logic [30:0] p_q;
    logic [2:0]  vld_q;

    assign vprod = 63'(x2_c[i]) * 63'(p_c[i]);
    assign mprod = 64'(v_q) * 64'(HORNER_M[i]);
    assign qk    = q0_q * 32'(HORNER_K[i]);
    assign rem   = vb_q - qk;
    assign corr  = rem >= 32'(HORNER_K[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // product with the running term
        v_q   <= vprod[61:30];
        xa_q  <= x_c[i];
        x2a_q <= x2_c[i];
        // quotient estimate by reciprocal
        q0_q  <= 32'(mprod >> HORNER_S[i]);
        vb_q  <= v_q;
        xb_q  <= xa_q;
        x2b_q <= x2a_q;
        // remainder fix-up and new term
        p_q   <= Q30_ONE - 31'(q0_q) - 31'(corr);
        xc_q  <= xb_q;
        x2c_q <= x2b_q;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= '0;
      end else if (en_i) begin
        vld_q <= {vld_q[1:0], vld_c[i]};
      end
    end

    assign p_c[i+1]   = p_q;
    assign x_c[i+1]   = xc_q;
    assign x2_c[i+1]  = x2c_q;
    assign vld_c[i+1] = vld_q[2];
  end

  assign yprod = 62'(x_c[HORNER_STEPS]) * 62'(p_c[HORNER_STEPS]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q <= yprod[60:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldf_q <= 1'b0;
    end else if (en_i) begin
      vldf_q <= vld_c[HORNER_STEPS];
    end
  end

  assign valid_o = vldf_q;
  assign sine_o  = sine_q;

endmodule

FILE: hdl/etrm_sincos.sv
// ----------------------------------------------------------------------------
// Angle to sine and cosine
// Splits a binary angle into quadrant and offset and maps two kernel results.
// ----------------------------------------------------------------------------
module etrm_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic                  valid_o,
  output etrm_pkg::q30_t        sin_o,
  output etrm_pkg::q30_t        cos_o
);
  import etrm_pkg::*;

  localparam int RW = ANGLE_BITS - 2;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [1:0]  quad;
  logic [30:0] t;
  logic [30:0] f_c;
  logic        s_vld;
  logic        c_vld;
  logic [30:0] s_raw;
  logic [30:0] c_raw;
  q30_t        sm;
  q30_t        cm;
  logic [1:0]  quad_q [QS_LAT];
  q30_t        sin_d;
  q30_t        cos_d;
  q30_t        sin_q;
  q30_t        cos_q;
  logic        valid_q;

  assign quad = angle_i[ANGLE_BITS-1 -: 2];
  assign t    = 31'(angle_i[RW-1:0]) << (30 - RW);
  assign f_c  = Q30_ONE - t;

  etrm_qsine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .f_i     (t),
    .valid_o (s_vld),
    .sine_o  (s_raw)
  );

  etrm_qsine u_cosine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .f_i     (f_c),
    .valid_o (c_vld),
    .sine_o  (c_raw)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= quad;
      for (int k = 1; k < QS_LAT; k++) begin
        quad_q[k] <= quad_q[k-1];
      end
    end
  end

  // clamp to one
  assign sm = q30_t'({1'b0, (s_raw > Q30_ONE) ? Q30_ONE : s_raw});
  assign cm = q30_t'({1'b0, (c_raw > Q30_ONE) ? Q30_ONE : c_raw});

  always_comb begin
    case (quad_q[QS_LAT-1])
      QUAD_0: begin
        sin_d = sm;
        cos_d = cm;
      end
      QUAD_1: begin
        sin_d = cm;
        cos_d = -sm;
      end
      QUAD_2: begin
        sin_d = -sm;
        cos_d = -cm;
      end
      QUAD_3: begin
        sin_d = -cm;
        cos_d = sm;
      end
      default: begin
        sin_d = sm;
        cos_d = cm;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= s_vld & c_vld;
    end
  end

  assign valid_o = valid_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

FILE: hdl/etrm_matrix.sv
// ----------------------------------------------------------------------------
// Rotation matrix products
// Forms the Z-Y-X basis vectors from sines and cosines, rounds and saturates.
// ----------------------------------------------------------------------------
module etrm_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  etrm_pkg::q30_t   sy_i,
  input  etrm_pkg::q30_t   cy_i,
  input  etrm_pkg::q30_t   sp_i,
  input  etrm_pkg::q30_t   cp_i,
  input  etrm_pkg::q30_t   sr_i,
  input  etrm_pkg::q30_t   cr_i,
  output logic             valid_o,
  output etrm_pkg::basis_t res_o
);
  import etrm_pkg::*;

  localparam int   SH       = 30 - FRAC_BITS;
  localparam sum_t HALF     = sum_t'((2 ** SH) / 2);
  localparam sum_t HALF_ADJ = (SH == 0) ? sum_t'(0) : sum_t'((2 ** SH) / 2 - 1);
  localparam sum_t LIM      = sum_t'(2 ** FRAC_BITS);

  function automatic elem_t to_out(input sum_t v);
    sum_t r;
    r = v[SUM_W-1] ? (v + HALF_ADJ) >>> SH : (v + HALF) >>> SH;
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r[15:0];
  endfunction

  logic [5:0] vld_q;

  // first products
  prod_t pr_cysp_q, pr_sysp_q, pr_cycp_q, pr_sycp_q, pr_sycr_q;
  prod_t pr_cycr_q, pr_cpsr_q, pr_sysr_q, pr_cysr_q, pr_cpcr_q;
  q30_t  sr0_q, cr0_q, sp0_q;
  // first rounding
  q30_t  cysp_q, sysp_q, fx1_q, fy1_q, sycr1_q, cycr1_q, lz1_q, sysr1_q, cysr1_q, uz1_q;
  q30_t  sr1_q, cr1_q, sp1_q;
  // second products
  prod_t pr_cyspsr_q, pr_syspsr_q, pr_cyspcr_q, pr_syspcr_q;
  q30_t  fx2_q, fy2_q, lz2_q, uz2_q, sp2_q, sycr2_q, cycr2_q, sysr2_q, cysr2_q;
  // second rounding
  q30_t  cyspsr_q, syspsr_q, cyspcr_q, syspcr_q;
  q30_t  fx3_q, fy3_q, lz3_q, uz3_q, sp3_q, sycr3_q, cycr3_q, sysr3_q, cysr3_q;
  // sums and result
  sum_t   sum_q [9];
  basis_t res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_cysp_q <= prod_t'(cy_i) * prod_t'(sp_i);
      pr_sysp_q <= prod_t'(sy_i) * prod_t'(sp_i);
      pr_cycp_q <= prod_t'(cy_i) * prod_t'(cp_i);
      pr_sycp_q <= prod_t'(sy_i) * prod_t'(cp_i);
      pr_sycr_q <= prod_t'(sy_i) * prod_t'(cr_i);
      pr_cycr_q <= prod_t'(cy_i) * prod_t'(cr_i);
      pr_cpsr_q <= prod_t'(cp_i) * prod_t'(sr_i);
      pr_sysr_q <= prod_t'(sy_i) * prod_t'(sr_i);
      pr_cysr_q <= prod_t'(cy_i) * prod_t'(sr_i);
      pr_cpcr_q <= prod_t'(cp_i) * prod_t'(cr_i);
      sr0_q     <= sr_i;
      cr0_q     <= cr_i;
      sp0_q     <= sp_i;

      cysp_q  <= round_q30(pr_cysp_q);
      sysp_q  <= round_q30(pr_sysp_q);
      fx1_q   <= round_q30(pr_cycp_q);
      fy1_q   <= round_q30(pr_sycp_q);
      sycr1_q <= round_q30(pr_sycr_q);
      cycr1_q <= round_q30(pr_cycr_q);
      lz1_q   <= round_q30(pr_cpsr_q);
      sysr1_q <= round_q30(pr_sysr_q);
      cysr1_q <= round_q30(pr_cysr_q);
      uz1_q   <= round_q30(pr_cpcr_q);
      sr1_q   <= sr0_q;
      cr1_q   <= cr0_q;
      sp1_q   <= sp0_q;

      pr_cyspsr_q <= prod_t'(cysp_q) * prod_t'(sr1_q);
      pr_syspsr_q <= prod_t'(sysp_q) * prod_t'(sr1_q);
      pr_cyspcr_q <= prod_t'(cysp_q) * prod_t'(cr1_q);
      pr_syspcr_q <= prod_t'(sysp_q) * prod_t'(cr1_q);
      fx2_q       <= fx1_q;
      fy2_q       <= fy1_q;
      lz2_q       <= lz1_q;
      uz2_q       <= uz1_q;
      sp2_q       <= sp1_q;
      sycr2_q     <= sycr1_q;
      cycr2_q     <= cycr1_q;
      sysr2_q     <= sysr1_q;
      cysr2_q     <= cysr1_q;

      cyspsr_q <= round_q30(pr_cyspsr_q);
      syspsr_q <= round_q30(pr_syspsr_q);
      cyspcr_q <= round_q30(pr_cyspcr_q);
      syspcr_q <= round_q30(pr_syspcr_q);
      fx3_q    <= fx2_q;
      fy3_q    <= fy2_q;
      lz3_q    <= lz2_q;
      uz3_q    <= uz2_q;
      sp3_q    <= sp2_q;
      sycr3_q  <= sycr2_q;
      cycr3_q  <= cycr2_q;
      sysr3_q  <= sysr2_q;
      cysr3_q  <= cysr2_q;

      sum_q[0] <= sum_t'(fx3_q);
      sum_q[1] <= sum_t'(fy3_q);
      sum_q[2] <= -sum_t'(sp3_q);
      sum_q[3] <= sum_t'(cyspsr_q) - sum_t'(sycr3_q);
      sum_q[4] <= sum_t'(syspsr_q) + sum_t'(cycr3_q);
      sum_q[5] <= sum_t'(lz3_q);
      sum_q[6] <= sum_t'(cyspcr_q) + sum_t'(sysr3_q);
      sum_q[7] <= sum_t'(syspcr_q) - sum_t'(cysr3_q);
      sum_q[8] <= sum_t'(uz3_q);

      res_q.fwd_x  <= to_out(sum_q[0]);
      res_q.fwd_y  <= to_out(sum_q[1]);
      res_q.fwd_z  <= to_out(sum_q[2]);
      res_q.left_x <= to_out(sum_q[3]);
      res_q.left_y <= to_out(sum_q[4]);
      res_q.left_z <= to_out(sum_q[5]);
      res_q.up_x   <= to_out(sum_q[6]);
      res_q.up_y   <= to_out(sum_q[7]);
      res_q.up_z   <= to_out(sum_q[8]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];
  assign res_o   = res_q;

endmodule

FILE: hdl/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// Euler to rotation matrix
// Z-Y-X yaw, pitch and roll to the forward, left and up basis vectors.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall_o is low and returns one result
// per item, in order. Each item passes through the quarter-wave sine
// kernels (scale, square, five polynomial steps of three stages each, final
// product), the quadrant mapping register, the matrix products, rounding,
// sums and saturation, and the output register.
// A two-entry output buffer absorbs a stall from the receiver; in_stall_o is
// raised only once its second entry fills, and the whole pipeline then holds.
// Entries are signed Q1.FRAC_BITS, rounded half away from zero and saturated
// to plus or minus one.
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        yaw_i,
  input  logic [15:0]        pitch_i,
  input  logic [15:0]        roll_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] fwd_x_o,
  output logic signed [15:0] fwd_y_o,
  output logic signed [15:0] fwd_z_o,
  output logic signed [15:0] left_x_o,
  output logic signed [15:0] left_y_o,
  output logic signed [15:0] left_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o
);
  import etrm_pkg::*;

  logic   en;
  logic   take;
  logic   vy, vp, vr;
  q30_t   sy, cy, sp, cp, sr, cr;
  logic   pipe_valid;
  basis_t pipe_res;

  logic   out_valid_d, out_valid_q;
  logic   skid_valid_d, skid_valid_q;
  basis_t out_d, out_q;
  basis_t skid_d, skid_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign take       = out_valid_q && !out_stall_i;

  etrm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .angle_i (ANGLE_BITS'(yaw_i)),
    .valid_o (vy),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  etrm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .angle_i (ANGLE_BITS'(pitch_i)),
    .valid_o (vp),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  etrm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .angle_i (ANGLE_BITS'(roll_i)),
    .valid_o (vr),
    .sin_o   (sr),
    .cos_o   (cr)
  );

  etrm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vy & vp & vr),
    .sy_i    (sy),
    .cy_i    (cy),
    .sp_i    (sp),
    .cp_i    (cp),
    .sr_i    (sr),
    .cr_i    (cr),
    .valid_o (pipe_valid),
    .res_o   (pipe_res)
  );

  // output register with skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_d = pipe_valid;
      out_d       = pipe_res;
    end else if (pipe_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = pipe_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign fwd_x_o     = out_q.fwd_x;
  assign fwd_y_o     = out_q.fwd_y;
  assign fwd_z_o     = out_q.fwd_z;
  assign left_x_o    = out_q.left_x;
  assign left_y_o    = out_q.left_y;
  assign left_z_o    = out_q.left_z;
  assign up_x_o      = out_q.up_x;
  assign up_y_o      = out_q.up_y;
  assign up_z_o      = out_q.up_z;

endmodule
